// ===== design/kwc_pkg.sv =====
// Shared types, constants and character functions of the keyword word counter.
package kwc_pkg;

	// Configuration register layout.
	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int SLOT_W    = 44;
	localparam int LEN_LSB   = 40;
	localparam int LEN_W     = 3;
	localparam int CLASS_BIT = 43;

	// Result field width and parameter defaults.
	localparam int OUT_W                 = 32;
	localparam int WORD_LIMIT_DEF        = 255;
	localparam int PATTERN_BYTES_DEF     = 5;
	localparam int PATTERN_SLOTS_DEF     = 8;
	localparam int COUNT_WIDTH_DEF       = 32;

	typedef logic [7:0]        byte_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// Reset contents: five war stems, one peace stem, two empty slots.
	localparam slot_t CFG_RESET [CFG_COUNT] = '{
		44'd4402038042338, 44'd4402037780194, 44'd4402037976802,
		44'd3298551590626, 44'd6463437532898, 44'd12094643693804,
		44'd0, 44'd0
	};

	// Case folding constants.
	localparam byte_t FOLD_OFFSET = 8'd32;
	localparam byte_t YO_UPPER    = 8'd168;
	localparam byte_t YO_LOWER    = 8'd184;

	typedef enum logic [1:0] {
		VERDICT_EQUAL = 2'd0,
		VERDICT_WAR   = 2'd1,
		VERDICT_PEACE = 2'd2
	} verdict_t;

	// Per-byte classification handed from the matcher to the word state.
	typedef struct packed {
		logic  delim;
		byte_t folded;
		logic  war_match;
		logic  peace_match;
	} match_t;

	// True for bytes that end a word.
	function automatic logic is_delim(input byte_t c);
		return c inside {8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2E, 8'h2C, 8'h3B,
			8'h3A, 8'h21, 8'h3F, 8'h22, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B,
			8'h7D, 8'h2D};
	endfunction

	// Lower-case Latin and CP1251 Cyrillic letters.
	function automatic byte_t fold(input byte_t c);
		byte_t r;
		case (c) inside
			[8'h41:8'h5A], [8'hC0:8'hDF]: r = c + FOLD_OFFSET;
			YO_UPPER: r = YO_LOWER;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

// ===== design/keyword_word_counter.sv =====
// Keyword word counter: input register, word state, counters and result register.
//
// Text enters one byte per transaction on the byte channel (text_byte,
// end_of_text, byte_valid, byte_stall). Bytes are split into words at
// delimiters, case-folded, and each word counts once per class if any
// pattern of that class ends within its first WORD_LIMIT bytes.
// A byte marked end_of_text closes the text: one transaction on the
// result channel carries both saturated totals and the verdict, and all
// word and counter state returns to zero.
// Throughput is one byte per cycle while byte_stall is low; a byte is
// registered in the input register on acceptance and processed from there,
// and result_valid rises once the totals of its closing byte are loaded into
// the result register. The rate is set by the update of the history and counters.
// While a result waits under result_stall, ordinary bytes still flow; only
// a second closing byte holds byte_stall high until the result is taken.
// Pattern slots are written on the cfg channel (cfg_ready is always high)
// and are only to be written while no text is in flight.
// Reset (arst_n low) restores the built-in patterns and clears the valid flags,
// word state and counters; no clearing pass is needed.
module keyword_word_counter #(
	parameter int WORD_LIMIT    = kwc_pkg::WORD_LIMIT_DEF,
	parameter int PATTERN_BYTES = kwc_pkg::PATTERN_BYTES_DEF,
	parameter int PATTERN_SLOTS = kwc_pkg::PATTERN_SLOTS_DEF,
	parameter int COUNT_WIDTH   = kwc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  kwc_pkg::byte_t                text_byte,
	input  logic                          end_of_text,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kwc_pkg::OUT_W-1:0]     war_total,
	output logic [kwc_pkg::OUT_W-1:0]     peace_total,
	output kwc_pkg::verdict_t             verdict,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  kwc_pkg::slot_t                cfg_data
);
	import kwc_pkg::*;

	localparam int WL_W = $clog2(WORD_LIMIT + 1);

	slot_t            slots [CFG_COUNT];
	logic             valid_s1;
	byte_t            byte_s1;
	logic             eot_s1;
	logic             advance;
	match_t           m;
	byte_t            hist_q [PATTERN_BYTES];
	logic [WL_W-1:0]  word_len_q;
	logic             war_hit_q;
	logic             peace_hit_q;
	logic [COUNT_WIDTH-1:0] war_cnt_q;
	logic [COUNT_WIDTH-1:0] peace_cnt_q;
	logic             take;
	logic             close;
	logic [WL_W-1:0]  wl_upd;
	logic             war_upd;
	logic             peace_upd;
	logic [COUNT_WIDTH-1:0] war_next;
	logic [COUNT_WIDTH-1:0] peace_next;
	logic [OUT_W-1:0] war_clamp;
	logic [OUT_W-1:0] peace_clamp;
	verdict_t         verdict_next;
	logic             out_valid_q;

	kwc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.slots     (slots)
	);

	kwc_match #(
		.WORD_LIMIT    (WORD_LIMIT),
		.PATTERN_BYTES (PATTERN_BYTES),
		.PATTERN_SLOTS (PATTERN_SLOTS)
	) u_match (
		.text_byte (byte_s1),
		.hist      (hist_q),
		.word_len  (word_len_q),
		.slots     (slots),
		.result    (m)
	);

	// Flow control: only a closing byte waits, and only for the result register.
	assign advance    = valid_s1 && (!eot_s1 || !out_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// Word update: a byte is taken until the word limit, then ignored.
	always_comb begin
		take      = !m.delim && (word_len_q < WL_W'(WORD_LIMIT));
		close     = m.delim || eot_s1;
		wl_upd    = take ? word_len_q + WL_W'(1) : word_len_q;
		war_upd   = war_hit_q || (take && m.war_match);
		peace_upd = peace_hit_q || (take && m.peace_match);
		war_next  = war_cnt_q;
		peace_next = peace_cnt_q;
		if (close && wl_upd != '0) begin
			if (war_upd && war_cnt_q != '1) war_next = war_cnt_q + 1'b1;
			if (peace_upd && peace_cnt_q != '1) peace_next = peace_cnt_q + 1'b1;
		end
	end

	// Verdict on the full-width counters.
	always_comb begin
		if (war_next > peace_next) verdict_next = VERDICT_WAR;
		else if (peace_next > war_next) verdict_next = VERDICT_PEACE;
		else verdict_next = VERDICT_EQUAL;
	end

	// Totals fitted to the result field width, saturating when narrower.
	generate
		if (COUNT_WIDTH > OUT_W) begin : g_clamp
			assign war_clamp   = (|war_next[COUNT_WIDTH-1:OUT_W]) ? '1 : war_next[OUT_W-1:0];
			assign peace_clamp = (|peace_next[COUNT_WIDTH-1:OUT_W]) ? '1 :
				peace_next[OUT_W-1:0];
		end else begin : g_extend
			assign war_clamp   = OUT_W'(war_next);
			assign peace_clamp = OUT_W'(peace_next);
		end
	endgenerate

	// Word history, hit flags and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_BYTES; i++) hist_q[i] <= '0;
			word_len_q  <= '0;
			war_hit_q   <= 1'b0;
			peace_hit_q <= 1'b0;
			war_cnt_q   <= '0;
			peace_cnt_q <= '0;
		end else if (advance) begin
			if (close) begin
				for (int i = 0; i < PATTERN_BYTES; i++) hist_q[i] <= '0;
				word_len_q  <= '0;
				war_hit_q   <= 1'b0;
				peace_hit_q <= 1'b0;
			end else if (take) begin
				hist_q[0] <= m.folded;
				for (int i = 1; i < PATTERN_BYTES; i++) hist_q[i] <= hist_q[i-1];
				word_len_q  <= wl_upd;
				war_hit_q   <= war_upd;
				peace_hit_q <= peace_upd;
			end
			if (eot_s1) begin
				war_cnt_q   <= '0;
				peace_cnt_q <= '0;
			end else begin
				war_cnt_q   <= war_next;
				peace_cnt_q <= peace_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eot_s1) begin
			war_total   <= war_clamp;
			peace_total <= peace_clamp;
			verdict     <= verdict_next;
		end
	end

	assign result_valid = out_valid_q;

`ifndef ASSERT_OFF
	// The word length never passes the examined limit.
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(word_len_q) <= WORD_LIMIT)
		else $error("word length beyond limit");

	// A closing byte leaves all counting state cleared.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eot_s1 |=> war_cnt_q == '0 && peace_cnt_q == '0 && word_len_q == '0)
		else $error("state not cleared after end of text");

	// Input is held back only for a closing byte facing a full result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && eot_s1 && out_valid_q && result_stall)
		else $error("input stalled without cause");

	// Verdict is war whenever the reported war total exceeds the peace total.
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && war_total > peace_total |-> verdict == VERDICT_WAR)
		else $error("verdict disagrees with totals");
`endif

endmodule

// ===== design/kwc_cfg_regs.sv =====
// Pattern slot registers written through the configuration channel.
module kwc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  kwc_pkg::slot_t                cfg_data,
	output kwc_pkg::slot_t                slots [kwc_pkg::CFG_COUNT]
);
	import kwc_pkg::*;

	slot_t slot_q [CFG_COUNT];

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Slot storage, reset to the built-in stems.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) slot_q[i] <= CFG_RESET[i];
		end else if (cfg_valid && cfg_ready) begin
			slot_q[cfg_index] <= cfg_data;
		end
	end

	assign slots = slot_q;

endmodule

// ===== design/kwc_match.sv =====
// Folds one byte and compares all pattern slots against the updated history.
module kwc_match #(
	parameter int WORD_LIMIT    = kwc_pkg::WORD_LIMIT_DEF,
	parameter int PATTERN_BYTES = kwc_pkg::PATTERN_BYTES_DEF,
	parameter int PATTERN_SLOTS = kwc_pkg::PATTERN_SLOTS_DEF,
	localparam int WL_W         = $clog2(WORD_LIMIT + 1)
) (
	input  kwc_pkg::byte_t  text_byte,
	input  kwc_pkg::byte_t  hist [PATTERN_BYTES],
	input  logic [WL_W-1:0] word_len,
	input  kwc_pkg::slot_t  slots [kwc_pkg::CFG_COUNT],
	output kwc_pkg::match_t result
);
	import kwc_pkg::*;

	byte_t newh [PATTERN_BYTES];

	// History as it stands once this byte is shifted in, newest first.
	always_comb begin
		newh[0] = fold(text_byte);
		for (int i = 1; i < PATTERN_BYTES; i++) newh[i] = hist[i-1];
	end

	// Every slot compared in parallel; lengths above the history depth are clamped.
	always_comb begin
		logic [LEN_W-1:0] eff;
		logic             hit;
		logic             eq;
		result.delim       = is_delim(text_byte);
		result.folded      = newh[0];
		result.war_match   = 1'b0;
		result.peace_match = 1'b0;
		for (int s = 0; s < PATTERN_SLOTS; s++) begin
			eff = slots[s][LEN_LSB +: LEN_W];
			if (eff > LEN_W'(PATTERN_BYTES)) eff = LEN_W'(PATTERN_BYTES);
			hit = 1'b0;
			for (int l = 1; l <= PATTERN_BYTES; l++) begin
				eq = (32'(word_len) >= l - 1);
				for (int i = 0; i < l; i++) begin
					if (slots[s][8*i +: 8] != newh[l-1-i]) eq = 1'b0;
				end
				if (eff == LEN_W'(l) && eq) hit = 1'b1;
			end
			if (hit) begin
				if (slots[s][CLASS_BIT]) result.peace_match = 1'b1;
				else result.war_match = 1'b1;
			end
		end
	end

endmodule
